FILE: sv/url_percent_decoder_core_macros.svh
// Assertion macros used by the decoder back end (upd_back).
`ifndef URL_PERCENT_DECODER_CORE_MACROS_SVH
`define URL_PERCENT_DECODER_CORE_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define UPD_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check that cons holds in the cycle after ante.
`define UPD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/upd_pkg.sv
// Types, constants and codes shared by the percent decoder modules.
`default_nettype none

package upd_pkg;

  // Width of the decoded-byte counter.
  localparam int COUNT_BITS = 16;
  // Width of the reported length and of the capacity register.
  localparam int LEN_W = 16;
  // Width wide enough to compare the counter against the capacity limit.
  localparam int CMP_W = (COUNT_BITS > LEN_W) ? COUNT_BITS : LEN_W;
  localparam logic [CMP_W-1:0] COUNT_MAX = CMP_W'({COUNT_BITS{1'b1}});

  localparam logic [LEN_W-1:0] CAP_RESET = LEN_W'(256);

  // Queue geometry, used on both sides.
  localparam int QUEUE_AW = 1;
  localparam int QUEUE_DEPTH = 2 ** QUEUE_AW;

  // Characters with a special meaning.
  localparam logic [7:0] PCT_CHAR   = 8'h25;
  localparam logic [7:0] PLUS_CHAR  = 8'h2B;
  localparam logic [7:0] SPACE_CHAR = 8'h20;

  // Status codes.
  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_BAD_HEX    = 2'd1;
  localparam logic [1:0] ST_INCOMPLETE = 2'd2;
  localparam logic [1:0] ST_OVERFLOW   = 2'd3;

  // Escape phases.
  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_HIGH = 2'd1;
  localparam logic [1:0] PH_LOW  = 2'd2;

  typedef struct packed {
    logic [7:0] char_code;
    logic       is_end;
  } in_item_t;

  typedef struct packed {
    logic             out_valid;
    logic [7:0]       out_byte;
    logic             done_res;
    logic [1:0]       status;
    logic [LEN_W-1:0] decoded_length;
  } out_item_t;

  // Classified character, passed from front to back.
  typedef struct packed {
    logic [7:0] char_code;
    logic       is_end;
    logic       is_pct;
    logic       is_plus;
    logic       hex_ok;
    logic [3:0] hex_val;
  } cmd_t;

endpackage

`default_nettype wire

FILE: sv/upd_front.sv
// Front end: accepts characters, classifies them and queues them for the back end.
`default_nettype none

module upd_front (
  input  wire               clk,
  input  wire               rst,
  input  wire               push,
  output logic              full,
  input  upd_pkg::in_item_t in_item,
  output logic              cmd_valid,
  output upd_pkg::cmd_t     cmd,
  input  wire               cmd_take
);

  upd_pkg::cmd_t               cls;
  upd_pkg::cmd_t               entry [upd_pkg::QUEUE_DEPTH];
  logic [upd_pkg::QUEUE_AW-1:0] wr_ptr;
  logic [upd_pkg::QUEUE_AW-1:0] rd_ptr;
  logic [upd_pkg::QUEUE_AW:0]   count;
  logic                         do_push;
  logic                         do_pop;

  // Classify the incoming character.
  always_comb begin
    cls.char_code = in_item.char_code;
    cls.is_end    = in_item.is_end;
    cls.is_pct    = (in_item.char_code == upd_pkg::PCT_CHAR);
    cls.is_plus   = (in_item.char_code == upd_pkg::PLUS_CHAR);
    cls.hex_ok    = 1'b1;
    cls.hex_val   = 4'd0;
    if (in_item.char_code inside {[8'h30:8'h39]}) begin
      cls.hex_val = 4'(in_item.char_code - 8'h30);
    end else if (in_item.char_code inside {[8'h41:8'h46]}) begin
      cls.hex_val = 4'(in_item.char_code - 8'h41 + 8'd10);
    end else if (in_item.char_code inside {[8'h61:8'h66]}) begin
      cls.hex_val = 4'(in_item.char_code - 8'h61 + 8'd10);
    end else begin
      cls.hex_ok = 1'b0;
    end
  end

  assign full      = (count == (upd_pkg::QUEUE_AW+1)'(upd_pkg::QUEUE_DEPTH));
  assign cmd_valid = (count != '0);
  assign do_push   = push && !full;
  assign do_pop    = cmd_take && cmd_valid;
  assign cmd       = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry[wr_ptr] <= cls;
    end
  end

endmodule

`default_nettype wire

FILE: sv/upd_back.sv
// Back end: decode state, capacity register and the result queue.
`default_nettype none

`include "url_percent_decoder_core_macros.svh"

module upd_back (
  input  wire                       clk,
  input  wire                       rst,
  input  wire                       cmd_valid,
  input  upd_pkg::cmd_t             cmd,
  output logic                      cmd_take,
  input  wire                       cfg_valid,
  output logic                      cfg_ready,
  input  wire [upd_pkg::LEN_W-1:0]  cfg_data,
  output logic                      empty,
  input  wire                       pop,
  output upd_pkg::out_item_t        out_item
);

  logic [upd_pkg::LEN_W-1:0]      cap;
  logic [1:0]                     phase, phase_next;
  logic [3:0]                     high_nib, high_nib_next;
  logic                           high_bad, high_bad_next;
  logic [upd_pkg::COUNT_BITS-1:0] out_count, out_count_next;
  logic                           halted, halted_next;
  logic [1:0]                     err_code, err_code_next;

  logic [upd_pkg::CMP_W-1:0]      lim_raw;
  logic [upd_pkg::CMP_W-1:0]      lim;
  logic                           at_limit;
  logic                           fire;
  upd_pkg::out_item_t             res_in;

  upd_pkg::out_item_t             entry [upd_pkg::QUEUE_DEPTH];
  logic [upd_pkg::QUEUE_AW-1:0]   wr_ptr;
  logic [upd_pkg::QUEUE_AW-1:0]   rd_ptr;
  logic [upd_pkg::QUEUE_AW:0]     count;
  logic                           res_full;
  logic                           do_pop;

  assign cfg_ready = 1'b1;

  // Length limit: capacity minus one, floored at zero, capped by the counter range.
  assign lim_raw  = (cap == '0) ? '0 : upd_pkg::CMP_W'(cap) - 1'b1;
  assign lim      = (lim_raw > upd_pkg::COUNT_MAX) ? upd_pkg::COUNT_MAX : lim_raw;
  assign at_limit = (upd_pkg::CMP_W'(out_count) >= lim);

  assign res_full = (count == (upd_pkg::QUEUE_AW+1)'(upd_pkg::QUEUE_DEPTH));
  assign fire     = cmd_valid && !res_full;
  assign cmd_take = fire;

  always_comb begin
    phase_next     = phase;
    high_nib_next  = high_nib;
    high_bad_next  = high_bad;
    out_count_next = out_count;
    halted_next    = halted;
    err_code_next  = err_code;
    res_in         = '0;
    if (cmd.is_end) begin
      res_in.done_res       = 1'b1;
      res_in.status         = halted ? err_code :
                              ((phase != upd_pkg::PH_IDLE) ? upd_pkg::ST_INCOMPLETE
                                                           : upd_pkg::ST_OK);
      res_in.decoded_length = upd_pkg::LEN_W'(out_count);
      phase_next     = upd_pkg::PH_IDLE;
      high_nib_next  = 4'd0;
      high_bad_next  = 1'b0;
      out_count_next = '0;
      halted_next    = 1'b0;
      err_code_next  = upd_pkg::ST_OK;
    end else begin
      if (!halted) begin
        case (phase)
          upd_pkg::PH_IDLE: begin
            if (at_limit) begin
              err_code_next = upd_pkg::ST_OVERFLOW;
              halted_next   = 1'b1;
            end else if (cmd.is_pct) begin
              phase_next = upd_pkg::PH_HIGH;
            end else begin
              res_in.out_valid = 1'b1;
              res_in.out_byte  = cmd.is_plus ? upd_pkg::SPACE_CHAR : cmd.char_code;
            end
          end
          upd_pkg::PH_HIGH: begin
            high_nib_next = cmd.hex_val;
            high_bad_next = !cmd.hex_ok;
            phase_next    = upd_pkg::PH_LOW;
          end
          default: begin
            // Low digit; an unused phase code behaves the same.
            if (high_bad || !cmd.hex_ok) begin
              err_code_next = upd_pkg::ST_BAD_HEX;
              halted_next   = 1'b1;
              phase_next    = upd_pkg::PH_IDLE;
            end else begin
              res_in.out_valid = 1'b1;
              res_in.out_byte  = {high_nib, cmd.hex_val};
              phase_next       = upd_pkg::PH_IDLE;
            end
          end
        endcase
        if (res_in.out_valid) begin
          out_count_next = out_count + 1'b1;
        end
      end
      res_in.status         = err_code_next;
      res_in.decoded_length = upd_pkg::LEN_W'(out_count_next);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cap       <= upd_pkg::CAP_RESET;
      phase     <= upd_pkg::PH_IDLE;
      high_nib  <= 4'd0;
      high_bad  <= 1'b0;
      out_count <= '0;
      halted    <= 1'b0;
      err_code  <= upd_pkg::ST_OK;
    end else begin
      if (cfg_valid && cfg_ready) begin
        cap <= cfg_data;
      end
      if (fire) begin
        phase     <= phase_next;
        high_nib  <= high_nib_next;
        high_bad  <= high_bad_next;
        out_count <= out_count_next;
        halted    <= halted_next;
        err_code  <= err_code_next;
      end
    end
  end

  // Result queue.
  assign empty    = (count == '0);
  assign do_pop   = pop && !empty;
  assign out_item = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (fire) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({fire, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      entry[wr_ptr] <= res_in;
    end
  end

  `UPD_ASSERT_NEXT(a_end_clears, fire && cmd.is_end, (out_count == '0) && !halted && (phase == upd_pkg::PH_IDLE), "stream state not cleared after end marker")
  `UPD_ASSERT_SAME(a_halted_silent, fire && halted && !cmd.is_end, !res_in.out_valid, "byte produced while halted")
  `UPD_ASSERT_NEXT(a_count_step, fire && res_in.out_valid, out_count == upd_pkg::COUNT_BITS'($past(out_count) + 1'b1), "count did not advance with a byte")

endmodule

`default_nettype wire

FILE: sv/url_percent_decoder_core.sv
// Top level of the streaming form-urlencoded percent decoder.
// Path: an item pushed is classified and written into the front queue, then decoded and
// written into the result queue, where it shows on out_item with empty low.
// Throughput: one item per cycle sustained while neither queue is full; each side holds a two-entry queue.
// Reset (rst, synchronous): queues empty, escape state and count cleared, capacity 256.
`default_nettype none

module url_percent_decoder_core (
  input  wire                      clk,
  input  wire                      rst,
  // Character input queue side.
  input  wire                      push,
  output logic                     full,
  input  upd_pkg::in_item_t        in_item,
  // Result queue side.
  output logic                     empty,
  input  wire                      pop,
  output upd_pkg::out_item_t       out_item,
  // Capacity register write channel.
  input  wire                      cfg_valid,
  output logic                     cfg_ready,
  input  wire [upd_pkg::LEN_W-1:0] cfg_data
);

  // Classified characters travel from front to back through the front queue.
  logic          cmd_valid;
  upd_pkg::cmd_t cmd;
  logic          cmd_take;

  // Front: classify each character ('%', '+', hex digit and value) and hold it
  // until the back end takes it. full is the front queue being full, so the
  // input keeps flowing while results wait downstream, until the front queue fills.
  upd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .in_item   (in_item),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_take  (cmd_take)
  );

  // Back: run the escape state machine, count decoded bytes against the
  // capacity limit, record the first error and drop characters after it,
  // and on the end marker report status and length and clear for the next
  // string. One result item per character, queued for the consumer.
  upd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_take  (cmd_take),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .empty     (empty),
    .pop       (pop),
    .out_item  (out_item)
  );

endmodule

`default_nettype wire

FILE: dv/url_percent_decoder_checker.sv
// Checker for the percent decoder: predicts every result and compares it with the block.
module url_percent_decoder_checker (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      push,
  input  logic                      full,
  input  upd_pkg::in_item_t         in_item,
  input  logic                      empty,
  input  logic                      pop,
  input  upd_pkg::out_item_t        out_item,
  input  logic                      cfg_valid,
  input  logic                      cfg_ready,
  input  logic [upd_pkg::LEN_W-1:0] cfg_data,
  output int                        mismatches,
  output int                        outstanding,
  output int                        checked
);
  import upd_pkg::*;

  // Shadow of the decoder state.
  logic [LEN_W-1:0]      capacity;
  logic [1:0]            esc_phase;
  logic [3:0]            hi_nibble;
  logic                  hi_bad;
  logic [COUNT_BITS-1:0] byte_count;
  logic                  stopped;
  logic [1:0]            err_code;

  out_item_t pending_results[$];
  int        error_tally;
  int        result_tally;
  int        pending_size;

  assign mismatches  = error_tally;
  assign outstanding = pending_size;
  assign checked     = result_tally;

  function automatic logic hex_digit(input logic [7:0] c, output logic [3:0] v);
    v = 4'h0;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = 4'(c - 8'h30);
      return 1'b1;
    end
    if (c >= 8'h41 && c <= 8'h46) begin
      v = 4'(c - 8'h41 + 8'd10);
      return 1'b1;
    end
    if (c >= 8'h61 && c <= 8'h66) begin
      v = 4'(c - 8'h61 + 8'd10);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  task automatic clear_string();
    esc_phase  = PH_IDLE;
    hi_nibble  = 4'h0;
    hi_bad     = 1'b0;
    byte_count = '0;
    stopped    = 1'b0;
    err_code   = ST_OK;
  endtask

  task automatic halt_decode(input logic [1:0] code);
    err_code  = code;
    stopped   = 1'b1;
    esc_phase = PH_IDLE;
  endtask

  // Advance the shadow state by one character and return the result it produces.
  task automatic decode_char(input in_item_t it, output out_item_t r);
    logic [CMP_W-1:0] limit;
    logic [3:0]       v;
    logic             ok;
    r = '0;
    limit = (capacity == '0) ? '0 : CMP_W'(capacity) - 1'b1;
    if (limit > COUNT_MAX)
      limit = COUNT_MAX;
    if (it.is_end) begin
      r.done_res = 1'b1;
      r.status = stopped ? err_code : (esc_phase != PH_IDLE ? ST_INCOMPLETE : ST_OK);
      r.decoded_length = LEN_W'(byte_count);
      clear_string();
    end else begin
      if (!stopped) begin
        if (esc_phase == PH_IDLE) begin
          if (CMP_W'(byte_count) >= limit) begin
            halt_decode(ST_OVERFLOW);
          end else if (it.char_code == PCT_CHAR) begin
            esc_phase = PH_HIGH;
          end else begin
            r.out_valid = 1'b1;
            r.out_byte = (it.char_code == PLUS_CHAR) ? SPACE_CHAR : it.char_code;
          end
        end else if (esc_phase == PH_HIGH) begin
          ok = hex_digit(it.char_code, v);
          hi_nibble = v;
          hi_bad = !ok;
          esc_phase = PH_LOW;
        end else begin
          ok = hex_digit(it.char_code, v);
          if (hi_bad || !ok) begin
            halt_decode(ST_BAD_HEX);
          end else begin
            r.out_valid = 1'b1;
            r.out_byte = {hi_nibble, v};
            esc_phase = PH_IDLE;
          end
        end
        if (r.out_valid)
          byte_count = byte_count + 1'b1;
      end
      r.status = err_code;
      r.decoded_length = LEN_W'(byte_count);
    end
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("MISMATCH %s: got %0d want %0d at %0t", what, got, want, $time);
    error_tally++;
  endtask

  always @(posedge clk) begin
    out_item_t exp_r;
    out_item_t next_r;
    if (rst) begin
      capacity = CAP_RESET;
      clear_string();
      pending_results.delete();
    end else begin
      if (pop && !empty) begin
        result_tally++;
        if (pending_results.size() == 0) begin
          report_mismatch("result with nothing expected", 0, 0);
        end else begin
          exp_r = pending_results.pop_front();
          if (out_item.out_valid !== exp_r.out_valid)
            report_mismatch("out_valid", out_item.out_valid, exp_r.out_valid);
          if (out_item.out_byte !== exp_r.out_byte)
            report_mismatch("out_byte", out_item.out_byte, exp_r.out_byte);
          if (out_item.done_res !== exp_r.done_res)
            report_mismatch("done_res", out_item.done_res, exp_r.done_res);
          if (out_item.status !== exp_r.status)
            report_mismatch("status", out_item.status, exp_r.status);
          if (out_item.decoded_length !== exp_r.decoded_length)
            report_mismatch("decoded_length", out_item.decoded_length,
                            exp_r.decoded_length);
        end
      end
      if (push && !full) begin
        decode_char(in_item, next_r);
        pending_results.push_back(next_r);
      end
      if (cfg_valid && cfg_ready)
        capacity = cfg_data;
    end
    pending_size = pending_results.size();
  end

endmodule

FILE: dv/tb_url_percent_decoder_core.sv
// Testbench top for the percent decoder: stimulus, flow control and the final verdict.
module tb_url_percent_decoder_core;
  import upd_pkg::*;

  localparam int ITEM_TARGET = 2000;
  // Receiver hold-off used to fill both queues and stall the input side.
  localparam int HOLD_CYCLES = 80;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               push = 1'b0;
  logic               full;
  in_item_t           in_item = '0;
  logic               empty;
  logic               pop = 1'b0;
  out_item_t          out_item;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [LEN_W-1:0]   cfg_data = '0;

  int mismatches;
  int outstanding;
  int checked;

  // Sender pacing: bursts of random length separated by random gaps.
  int burst_left = 0;
  bit steady = 1'b0;
  // Set by the stimulus to ask the receiver for one long hold-off.
  bit hold_req = 1'b0;

  int items_sent = 0;
  int strings_sent = 0;
  int cap_writes = 0;

  url_percent_decoder_core uut (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .in_item   (in_item),
    .empty     (empty),
    .pop       (pop),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  url_percent_decoder_checker checker_i (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .in_item     (in_item),
    .empty       (empty),
    .pop         (pop),
    .out_item    (out_item),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .mismatches  (mismatches),
    .outstanding (outstanding),
    .checked     (checked)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Hard stop in case the block hangs somewhere.
  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

  // Receiver: rotate through stall styles, and honor one long hold-off on request.
  initial begin
    int hold_left;
    int mode;
    int tick;
    logic [7:0] stall_mask;
    hold_left = 0;
    mode = 0;
    tick = 0;
    stall_mask = 8'hFF;
    forever begin
      @(negedge clk);
      tick++;
      if (tick % 50 == 0) begin
        mode = $urandom_range(0, 3);
        stall_mask = 8'($urandom_range(1, 255));
      end
      if (hold_req && hold_left == 0) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        case (mode)
          0: pop <= 1'b1;                              // drain at full rate
          1: pop <= 1'($urandom_range(0, 1));
          2: pop <= stall_mask[tick % 8];              // repeating stall pattern
          default: pop <= ($urandom_range(0, 3) == 0); // mostly stalled
        endcase
      end
    end
  end

  // Insert a gap between bursts unless the sender runs steady.
  task automatic pace();
    int gap;
    if (steady)
      return;
    if (burst_left == 0) begin
      // Occasional long burst gives stretches with no idling at all.
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                               : $urandom_range(1, 10);
      gap = $urandom_range(1, 6);
      @(negedge clk);
      push <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end else begin
      burst_left--;
    end
  endtask

  // Offer one item and hold it until the block takes it.
  task automatic send_item(input logic [7:0] c, input logic e);
    pace();
    @(negedge clk);
    push <= 1'b1;
    in_item <= '{char_code: c, is_end: e};
    @(posedge clk);
    while (full) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_end();
    // The character field is ignored on an end marker; randomize it anyway.
    send_item(8'($urandom_range(0, 255)), 1'b1);
    strings_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++)
      send_item(s[i], 1'b0);
  endtask

  // Drop push and wait until every expected result has come out.
  task automatic drain();
    @(negedge clk);
    push <= 1'b0;
    burst_left = 0;
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [LEN_W-1:0] cap);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= cap;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    cap_writes++;
  endtask

  function automatic logic [7:0] hex_char();
    int v;
    v = $urandom_range(0, 15);
    if (v < 10)
      return 8'(8'h30 + v);
    return $urandom_range(0, 1) ? 8'(8'h41 + v - 10) : 8'(8'h61 + v - 10);
  endfunction

  // Non-hex characters, most of them right next to a hex range boundary.
  function automatic logic [7:0] bad_hex_char();
    case ($urandom_range(0, 8))
      0: return 8'h2F;
      1: return 8'h3A;
      2: return 8'h40;
      3: return 8'h47;
      4: return 8'h60;
      5: return 8'h67;
      6: return 8'h00;
      7: return PCT_CHAR;
      default: return 8'hFF;
    endcase
  endfunction

  // One string: mostly well-formed elements with random content, some broken
  // escapes, some truncated escapes, and now and then plain byte noise.
  task automatic send_random_string();
    int n_el;
    int pick;
    bit cut;
    logic [7:0] c;
    cut = 1'b0;
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(0, 20)) send_item(8'($urandom_range(0, 255)), 1'b0);
    end else begin
      n_el = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 10);
      for (int i = 0; i < n_el && !cut; i++) begin
        pick = $urandom_range(0, 19);
        if (pick < 10) begin
          c = 8'($urandom_range(0, 255));
          if (c == PCT_CHAR)
            c = PLUS_CHAR;
          send_item(c, 1'b0);
        end else if (pick < 12) begin
          send_item(PLUS_CHAR, 1'b0);
        end else if (pick < 18) begin
          send_item(PCT_CHAR, 1'b0);
          send_item(hex_char(), 1'b0);
          send_item(hex_char(), 1'b0);
        end else if (pick == 18) begin
          // Broken escape: bad high or bad low digit.
          send_item(PCT_CHAR, 1'b0);
          if ($urandom_range(0, 1)) begin
            send_item(bad_hex_char(), 1'b0);
            send_item(hex_char(), 1'b0);
          end else begin
            send_item(hex_char(), 1'b0);
            send_item(bad_hex_char(), 1'b0);
          end
        end else begin
          // Truncated escape: the end marker follows right away.
          send_item(PCT_CHAR, 1'b0);
          case ($urandom_range(0, 2))
            0: ;
            1: send_item(hex_char(), 1'b0);
            default: send_item(bad_hex_char(), 1'b0);
          endcase
          cut = 1'b1;
        end
      end
    end
    send_end();
  endtask

  initial begin
    int phase_no;
    logic [LEN_W-1:0] cap;
    phase_no = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part at the reset capacity of 256.
    send_text("+%41%6a");                 // plus, upper and lower case escapes
    send_end();
    send_text("%Fgx");                    // bad low digit, then a dropped character
    send_end();
    send_text("%z");                      // bad high digit, end before the low one
    send_end();
    send_text("%");                       // end right after the percent sign
    send_end();
    send_item(8'h00, 1'b0);               // zero is an ordinary character
    send_item(8'hFF, 1'b0);
    send_text("%fF");
    send_end();
    drain();
    write_capacity(LEN_W'(1));            // no room at all: overflow at once
    send_text("a");
    send_end();

    // Random part, one capacity setting per phase.
    while (items_sent < ITEM_TARGET) begin
      case (phase_no)
        0: cap = '0;                        // zero capacity
        1: cap = '1;                        // largest capacity
        2: cap = LEN_W'(2);
        3: cap = LEN_W'(3);
        default: begin
          case ($urandom_range(0, 9))
            6: cap = CAP_RESET;
            7: cap = LEN_W'($urandom_range(1, 65535));
            8: cap = '1;
            9: cap = LEN_W'($urandom_range(0, 1));
            default: cap = LEN_W'($urandom_range(1, 24));
          endcase
        end
      endcase
      drain();
      write_capacity(cap);
      if (phase_no == 2) begin
        // Hold the receiver off while the sender keeps offering items.
        hold_req = 1'b1;
        steady = 1'b1;
      end
      repeat ($urandom_range(8, 20)) send_random_string();
      steady = 1'b0;
      phase_no++;
    end

    drain();
    $display("Sent %0d items in %0d strings across %0d capacity settings",
             items_sent, strings_sent, cap_writes);
    $display("Compared %0d results, including a long receiver hold-off", checked);
    if (mismatches == 0 && outstanding == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
